@@ rtl/neighbor_table_hop_gradient_unit_defines.svh @@
// Assertion macros for the neighbor table hop gradient unit.
// No dependencies; included by the top level.
`ifndef NEIGHBOR_TABLE_HOP_GRADIENT_UNIT_DEFINES_SVH
`define NEIGHBOR_TABLE_HOP_GRADIENT_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define NTHG_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define NTHG_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define NTHG_ASSERT(label, clk, rst_n, prop)
`define NTHG_ASSERT_RST(label, clk, prop)
`endif
`endif

@@ rtl/nthg_pkg.sv @@
// Package for the neighbor table hop gradient unit: constants, codes, state type.
// No dependencies.
package nthg_pkg;
  localparam int TABLE_DEPTH_DEF = 16;
  localparam logic [15:0] ANCHOR_ID_MAX = 16'd3;
  localparam logic [7:0] GRADIENT_NONE = 8'hff;
  localparam logic [7:0] RST_NEAR_LIMIT = 8'd60;
  localparam logic [7:0] RST_MAX_AGE = 8'd32;
  localparam logic [7:0] RST_CODE_JOINED = 8'd4;
  localparam logic [7:0] RST_CODE_MOVE_IN = 8'd3;
  localparam logic [7:0] RST_CODE_MOVE_OUT = 8'd2;

  localparam logic [2:0] REG_IS_ROOT = 3'd0;
  localparam logic [2:0] REG_NEAR_LIMIT = 3'd1;
  localparam logic [2:0] REG_MAX_AGE = 3'd2;
  localparam logic [2:0] REG_CODE_JOINED = 3'd3;
  localparam logic [2:0] REG_CODE_MOVE_IN = 3'd4;
  localparam logic [2:0] REG_CODE_MOVE_OUT = 3'd5;

  localparam logic OP_MESSAGE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SEARCH, ST_PURGE, ST_COPY, ST_GRAD, ST_OUT
  } state_t;
endpackage

@@ rtl/neighbor_table_hop_gradient_unit.sv @@
// Top level of the neighbor table hop gradient unit.
// Depends on nthg_pkg and neighbor_table_hop_gradient_unit_defines.svh.
`include "neighbor_table_hop_gradient_unit_defines.svh"

// One table entry is visited per cycle through a single registered memory read port
// and one compare unit. A message word walks the entries up to and including the hit
// (all live entries on a miss), then moves to the output state. A tick word purges
// stale entries, copying the last entry over each removed one, then walks the
// remaining entries for the gradient and moves to the output state. The output
// state holds while out_stall is high, and each word is accepted in the idle
// state. Input stall stays high until the result word has been taken.
module neighbor_table_hop_gradient_unit #(
  parameter int TABLE_DEPTH = nthg_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [15:0] in_neighbor_id,
  input  logic [7:0]  in_distance,
  input  logic [7:0]  in_neighbor_localized,
  input  logic [7:0]  in_neighbor_gradient,
  input  logic [7:0]  in_neighbor_state,
  input  logic signed [15:0] in_neighbor_x,
  input  logic signed [15:0] in_neighbor_y,
  input  logic        in_self_waiting,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_gradient,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] out_neighbor_count,
  output logic        out_gradient_changed,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH+1);
  localparam int EW = 16+32+8+8+8+8+16+16;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  // config registers
  logic       is_root_r;
  logic [7:0] near_limit_r, max_age_r, code_joined_r, code_move_in_r, code_move_out_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_root_r <= 1'b0;
      near_limit_r <= nthg_pkg::RST_NEAR_LIMIT;
      max_age_r <= nthg_pkg::RST_MAX_AGE;
      code_joined_r <= nthg_pkg::RST_CODE_JOINED;
      code_move_in_r <= nthg_pkg::RST_CODE_MOVE_IN;
      code_move_out_r <= nthg_pkg::RST_CODE_MOVE_OUT;
    end else if (cfg_valid) begin
      case (cfg_index)
        nthg_pkg::REG_IS_ROOT:       is_root_r <= cfg_data[0];
        nthg_pkg::REG_NEAR_LIMIT:    near_limit_r <= cfg_data;
        nthg_pkg::REG_MAX_AGE:       max_age_r <= cfg_data;
        nthg_pkg::REG_CODE_JOINED:   code_joined_r <= cfg_data;
        nthg_pkg::REG_CODE_MOVE_IN:  code_move_in_r <= cfg_data;
        nthg_pkg::REG_CODE_MOVE_OUT: code_move_out_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // entry memory: {ident, stamp, distance, localized, gradient, status, x, y}
  logic [EW-1:0] mem [TABLE_DEPTH];
  logic [EW-1:0] rd_data_r;
  logic [IW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [EW-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  logic [15:0] rd_ident;
  logic [31:0] rd_stamp;
  logic [7:0]  rd_dist, rd_grad, rd_stat;
  assign rd_ident = rd_data_r[EW-1 -: 16];
  assign rd_stamp = rd_data_r[EW-17 -: 32];
  assign rd_dist  = rd_data_r[EW-49 -: 8];
  assign rd_grad  = rd_data_r[EW-65 -: 8];
  assign rd_stat  = rd_data_r[EW-73 -: 8];

  // control and held input word
  nthg_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [31:0]   tick_r, tick_nxt;
  logic [7:0]    grad_r, grad_nxt, best_r, best_nxt;
  logic          chg_r, chg_nxt;
  logic          op_r, wait_r;
  logic [15:0]   id_r;
  logic [EW-49:0] pay_r;

  logic accept;
  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_operation;
      wait_r <= in_self_waiting;
      id_r <= in_neighbor_id;
      pay_r <= {in_distance, in_neighbor_localized, in_neighbor_gradient,
                in_neighbor_state, in_neighbor_x, in_neighbor_y};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nthg_pkg::ST_IDLE;
      count_r <= '0;
      tick_r <= '0;
      grad_r <= nthg_pkg::GRADIENT_NONE;
      chg_r <= 1'b0;
      idx_r <= '0;
      best_r <= nthg_pkg::GRADIENT_NONE;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      tick_r <= tick_nxt;
      grad_r <= grad_nxt;
      chg_r <= chg_nxt;
      idx_r <= idx_nxt;
      best_r <= best_nxt;
    end
  end

  // shared compare unit on the registered entry
  logic stale, counts;
  logic [31:0] age;
  assign age = tick_r - rd_stamp;
  assign stale = age > {24'd0, max_age_r};
  assign counts = !(wait_r && rd_ident > nthg_pkg::ANCHOR_ID_MAX
                    && rd_stat == code_joined_r)
                  && rd_dist < near_limit_r && rd_stat != code_move_in_r
                  && rd_stat != code_move_out_r;

  logic [7:0] fresh;
  always_comb begin
    if (is_root_r) fresh = 8'd0;
    else if (best_r == nthg_pkg::GRADIENT_NONE) fresh = best_r;
    else fresh = best_r + 8'd1;
  end

  // next state
  // SEARCH: idx_r is the entry whose data sits in rd_data_r (valid after one read).
  // PURGE: idx_r is entry k+1 (k = idx_r-1 read).
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nthg_pkg::ST_IDLE: if (accept)
        state_nxt = (in_operation == nthg_pkg::OP_TICK) ? nthg_pkg::ST_PURGE
                                                        : nthg_pkg::ST_SEARCH;
      nthg_pkg::ST_SEARCH:
        if (idx_r == count_r || rd_ident == id_r) state_nxt = nthg_pkg::ST_OUT;
      nthg_pkg::ST_PURGE:
        if (idx_r == '0) state_nxt = nthg_pkg::ST_GRAD;
        else if (stale) state_nxt = nthg_pkg::ST_COPY;
      nthg_pkg::ST_COPY: state_nxt = nthg_pkg::ST_PURGE;
      nthg_pkg::ST_GRAD: if (idx_r == count_r) state_nxt = nthg_pkg::ST_OUT;
      nthg_pkg::ST_OUT: if (!out_stall) state_nxt = nthg_pkg::ST_IDLE;
      default: state_nxt = nthg_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_nxt = count_r;
    idx_nxt = idx_r;
    tick_nxt = tick_r;
    grad_nxt = grad_r;
    chg_nxt = chg_r;
    best_nxt = best_r;
    rd_addr = idx_r[IW-1:0];
    wr_en = 1'b0;
    wr_addr = idx_r[IW-1:0];
    wr_data = {id_r, tick_r, pay_r};
    in_stall = (state_r != nthg_pkg::ST_IDLE);
    out_valid = (state_r == nthg_pkg::ST_OUT);
    case (state_r)
      nthg_pkg::ST_IDLE: begin
        rd_addr = '0;
        chg_nxt = 1'b0;
        best_nxt = nthg_pkg::GRADIENT_NONE;
        if (accept && in_operation == nthg_pkg::OP_TICK) begin
          tick_nxt = tick_r + 32'd1;
          // first purge read is entry count-1
          idx_nxt = count_r;
          rd_addr = IW'(count_r - CW'(1));
        end else begin
          idx_nxt = '0;
        end
      end
      nthg_pkg::ST_SEARCH: begin
        rd_addr = IW'(idx_r + CW'(1));
        if (idx_r == count_r || rd_ident == id_r) begin
          wr_en = 1'b1;
          if (idx_r == count_r) begin
            if (count_r < DEPTH_C) count_nxt = count_r + CW'(1);
            else wr_addr = IW'(TABLE_DEPTH - 1);
          end
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      nthg_pkg::ST_PURGE: begin
        if (idx_r == '0) begin
          rd_addr = '0;
        end else if (stale) begin
          // read last entry for the copy
          rd_addr = IW'(count_r - CW'(1));
        end else begin
          idx_nxt = idx_r - CW'(1);
          rd_addr = IW'(idx_r - CW'(2));
        end
      end
      nthg_pkg::ST_COPY: begin
        wr_en = 1'b1;
        wr_addr = IW'(idx_r - CW'(1));
        wr_data = rd_data_r;
        count_nxt = count_r - CW'(1);
        idx_nxt = idx_r - CW'(1);
        rd_addr = IW'(idx_r - CW'(2));
      end
      nthg_pkg::ST_GRAD: begin
        rd_addr = IW'(idx_r + CW'(1));
        if (idx_r == count_r) begin
          if (fresh != grad_r) chg_nxt = 1'b1;
          grad_nxt = fresh;
        end else begin
          if (counts && rd_grad < best_r) best_nxt = rd_grad;
          idx_nxt = idx_r + CW'(1);
        end
      end
      nthg_pkg::ST_OUT: ;
      default: ;
    endcase
  end

  assign out_gradient = grad_r;
  assign out_neighbor_count = count_r;
  assign out_gradient_changed = chg_r;

  `NTHG_ASSERT(a_count_bound, clk, rst_n, count_r <= DEPTH_C)
  `NTHG_ASSERT(a_root_zero, clk, rst_n, (out_valid && is_root_r && op_r) |-> out_gradient == 8'd0)
  `NTHG_ASSERT(a_msg_nochg, clk, rst_n, (out_valid && !op_r) |-> !out_gradient_changed)
  `NTHG_ASSERT(a_no_accept_busy, clk, rst_n, out_valid |-> in_stall)
endmodule
